// ===== hdl/rau_pkg.sv =====
// rau_pkg: commands, controller states and the command/status structs
// shared by the rational arithmetic controller, datapath and top level
// no dependencies
`timescale 1ns / 1ps

package rau_pkg;

    localparam int CMD_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_EQ  = 3'd4
    } cmd_t;

    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_CHECK,
        ST_GCD,
        ST_DIV_N,
        ST_DIV_D,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture operands
        logic mul_a;     // first pair of products
        logic mul_b;     // denominator product
        logic sum;       // form numerator and denominator magnitudes
        logic gcd_init;  // set up gcd registers
        logic gcd_step;  // one subtract-shift step of the gcd
        logic div_init;  // start a restoring division
        logic div_step;  // one quotient bit
        logic div_den;   // division runs on the denominator
        logic finish;    // register the result beat
    } dp_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic bad;       // zero denominator, zero divisor or unused command
        logic is_eq;     // equality test
        logic zero_num;  // numerator magnitude is zero
        logic gcd_done;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== hdl/rational_arith_unit.sv =====
// rational_arith_unit: top level of the rational arithmetic unit
// depends on rau_pkg, rau_ctrl, rau_datapath
`timescale 1ns / 1ps
//
// channel   ports                                   handshake
// command   command, a_num, a_den, b_num, b_den     start & !busy
// result    result_num, result_den, equal, status   done, one cycle
//
// the controller steps through ST_MUL_A, ST_MUL_B, ST_SUM and ST_CHECK; on
// error, equality or zero numerator it then goes straight to ST_DONE, otherwise
// it first runs the binary gcd and two bit-serial divisions (numerator, then
// denominator). busy stays high through the done cycle, so the next beat is
// taken in the cycle after the result at the earliest.
// reset clears the controller and the division counter; the result beat
// cannot be stalled.

module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    output logic                            done,
    input  logic [CMD_W-1:0]                command,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    output logic signed [NUM_OUT_W-1:0]     result_num,
    output logic [DEN_OUT_W-1:0]            result_den,
    output logic                            equal,
    output logic                            status
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // controller
    rau_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    // datapath
    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .command    (command),
        .a_num      (a_num),
        .a_den      (a_den),
        .b_num      (b_num),
        .b_den      (b_den),
        .stat       (stat),
        .result_num (result_num),
        .result_den (result_den),
        .equal      (equal),
        .status     (status)
    );

endmodule

// ===== hdl/rau_ctrl.sv =====
// rau_ctrl: sequencing state machine for the rational arithmetic unit
// depends on rau_pkg
`timescale 1ns / 1ps

module rau_ctrl
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl,
    output logic     busy,
    output logic     done
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and command outputs
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = (state_reg != ST_IDLE);
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                ctrl.mul_a = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                ctrl.mul_b = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                ctrl.sum   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.bad || stat.is_eq || stat.zero_num)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    ctrl.gcd_init = 1'b1;
                    state_next    = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (stat.gcd_done)
                begin
                    ctrl.div_init = 1'b1;
                    state_next    = ST_DIV_N;
                end
                else
                begin
                    ctrl.gcd_step = 1'b1;
                end
            end
            ST_DIV_N:
            begin
                if (stat.div_done)
                begin
                    ctrl.div_init = 1'b1;
                    ctrl.div_den  = 1'b1;
                    state_next    = ST_DIV_D;
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                end
            end
            ST_DIV_D:
            begin
                ctrl.div_den = 1'b1;
                if (stat.div_done)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/rau_datapath.sv =====
// rau_datapath: products, sign-magnitude sum, binary gcd and restoring
// division by the gcd; result registers
// depends on rau_pkg
`timescale 1ns / 1ps

module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_ctrl_t                     ctrl,
    input  logic [CMD_W-1:0]             command,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    output dp_stat_t                     stat,
    output logic signed [NUM_OUT_W-1:0]  result_num,
    output logic [DEN_OUT_W-1:0]         result_den,
    output logic                         equal,
    output logic                         status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;        // product width
    localparam int MW = 2 * W + 1;    // magnitude width, holds a sum of two
    localparam int CW = $clog2(MW + 1);
    localparam int SW = $clog2(MW + 1);

    logic [CMD_W-1:0]    cmd_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, q_reg;
    logic                nneg_reg, dneg_reg;
    logic [MW-1:0]       nmag_reg, dmag_reg;
    logic [MW-1:0]       gx_reg, gy_reg;
    logic [SW-1:0]       gsh_reg;
    logic [MW-1:0]       g_reg;
    logic [MW-1:0]       quo_reg, rem_reg, dvd_reg;
    logic [CW-1:0]       cnt_reg;
    logic [MW-1:0]       nq_reg;
    logic                busy_div_reg;

    logic                bad, is_eq, div_zero;
    logic signed [PW-1:0] mul_x, mul_y;
    logic signed [PW-1:0] mul_p;
    logic [MW-1:0]       m1, m2;
    logic                s1, s2;
    logic [MW-1:0]       gx_next, gy_next;
    logic [SW-1:0]       gsh_next;
    logic [MW:0]         rem_sh;
    logic [MW-1:0]       rem_next;

    assign is_eq = (cmd_reg == CMD_EQ);
    assign bad   = (cmd_reg > CMD_EQ) || (ad_reg == '0) || (bd_reg == '0);
    assign div_zero = (cmd_reg == CMD_DIV) && (bn_reg == '0);

    assign stat.bad      = bad || div_zero;
    assign stat.is_eq    = is_eq;
    assign stat.zero_num = (nmag_reg == '0);
    assign stat.gcd_done = (gy_reg == '0);
    assign stat.div_done = (cnt_reg == '0) && !busy_div_reg;

    // shared multiplier, operand selection by step (p1 has its own multiply)
    always_comb
    begin
        mul_x = PW'(an_reg);
        mul_y = PW'(bd_reg);
        if (ctrl.mul_a)
        begin
            if (cmd_reg == CMD_MUL)
            begin
                mul_x = PW'(an_reg);
                mul_y = PW'(bn_reg);
            end
            else
            begin
                mul_x = PW'(bn_reg);
                mul_y = PW'(ad_reg);
            end
        end
        else if (ctrl.mul_b)
        begin
            mul_x = PW'(ad_reg);
            mul_y = (cmd_reg == CMD_DIV) ? PW'(bn_reg) : PW'(bd_reg);
        end
    end
    assign mul_p = mul_x * mul_y;

    // signed terms to magnitudes; sign of the second term flipped for a subtract
    always_comb
    begin
        s1 = p1_reg[PW-1];
        s2 = p2_reg[PW-1];
        m1 = s1 ? MW'(-{p1_reg[PW-1], p1_reg}) : MW'({1'b0, p1_reg});
        m2 = s2 ? MW'(-{p2_reg[PW-1], p2_reg}) : MW'({1'b0, p2_reg});
        if (cmd_reg == CMD_SUB)
        begin
            s2 = !s2;
        end
    end

    // one binary gcd step: strip common twos, halve an even value, else subtract
    always_comb
    begin
        gx_next  = gx_reg;
        gy_next  = gy_reg;
        gsh_next = gsh_reg;
        if (!gx_reg[0] && !gy_reg[0])
        begin
            gx_next  = gx_reg >> 1;
            gy_next  = gy_reg >> 1;
            gsh_next = gsh_reg + SW'(1);
        end
        else if (!gx_reg[0])
        begin
            gx_next = gx_reg >> 1;
        end
        else if (!gy_reg[0])
        begin
            gy_next = gy_reg >> 1;
        end
        else if (gx_reg >= gy_reg)
        begin
            gx_next = (gx_reg - gy_reg) >> 1;
        end
        else
        begin
            gy_next = (gy_reg - gx_reg) >> 1;
        end
        // keep x odd-side nonzero: once x is zero swap
        if (gx_next == '0)
        begin
            gx_next = gy_next;
            gy_next = '0;
        end
    end

    // restoring division step
    assign rem_sh   = {rem_reg, dvd_reg[MW-1]};
    assign rem_next = (rem_sh >= {1'b0, g_reg}) ? MW'(rem_sh - {1'b0, g_reg})
                                                : rem_sh[MW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= command;
            an_reg  <= a_num;
            ad_reg  <= a_den;
            bn_reg  <= b_num;
            bd_reg  <= b_den;
        end
        if (ctrl.mul_a)
        begin
            p2_reg <= mul_p;
            p1_reg <= PW'(an_reg) * PW'((cmd_reg == CMD_DIV) ? bd_reg : bd_reg);
        end
        if (ctrl.mul_b)
        begin
            q_reg <= mul_p;
        end
        if (ctrl.sum)
        begin
            dneg_reg <= q_reg[PW-1];
            dmag_reg <= q_reg[PW-1] ? MW'(-{q_reg[PW-1], q_reg})
                                    : MW'({1'b0, q_reg});
            if (cmd_reg == CMD_MUL)
            begin
                nneg_reg <= s2;
                nmag_reg <= m2;
            end
            else if (cmd_reg == CMD_DIV || is_eq)
            begin
                nneg_reg <= s1;
                nmag_reg <= m1;
            end
            else if (s1 == s2)
            begin
                nneg_reg <= s1;
                nmag_reg <= m1 + m2;
            end
            else if (m1 >= m2)
            begin
                nneg_reg <= s1;
                nmag_reg <= m1 - m2;
            end
            else
            begin
                nneg_reg <= s2;
                nmag_reg <= m2 - m1;
            end
        end
        if (ctrl.gcd_init)
        begin
            gx_reg  <= nmag_reg;
            gy_reg  <= dmag_reg;
            gsh_reg <= '0;
        end
        else if (ctrl.gcd_step)
        begin
            gx_reg  <= gx_next;
            gy_reg  <= gy_next;
            gsh_reg <= gsh_next;
        end
        if (ctrl.div_init)
        begin
            if (!ctrl.div_den)
            begin
                g_reg <= gx_reg << gsh_reg;
            end
            else
            begin
                nq_reg <= quo_reg;
            end
            dvd_reg <= ctrl.div_den ? dmag_reg : nmag_reg;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[MW-2:0], (rem_sh >= {1'b0, g_reg})};
        end
    end

    // division bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            busy_div_reg <= 1'b0;
        end
        else if (ctrl.div_init)
        begin
            cnt_reg      <= CW'(MW);
            busy_div_reg <= 1'b1;
        end
        else if (ctrl.div_step)
        begin
            cnt_reg      <= cnt_reg - CW'(1);
            busy_div_reg <= (cnt_reg != CW'(1));
        end
    end

    // result beat registers
    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            result_num <= '0;
            result_den <= '0;
            equal      <= 1'b0;
            status     <= 1'b0;
            if (cmd_reg > CMD_EQ)
            begin
                status <= 1'b0;
            end
            else if (bad || div_zero)
            begin
                status <= 1'b1;
            end
            else if (is_eq)
            begin
                equal <= (p1_reg == p2_reg);
            end
            else if (nmag_reg == '0)
            begin
                result_den <= DEN_OUT_W'(1);
            end
            else
            begin
                result_num <= (nneg_reg != dneg_reg)
                              ? NUM_OUT_W'(-{1'b0, nq_reg}) : NUM_OUT_W'(nq_reg);
                result_den <= DEN_OUT_W'(quo_reg);
            end
        end
    end

endmodule
